@@ rtl/core/ptd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared widths, constants and types of the trial-division primality tester.
// ----------------------------------------------------------------------------
package ptd_pkg;

    localparam int NUMBER_WIDTH = 32;
    // divisor stays below 2^(W/2) + 8, square below 2^(W+1)
    localparam int DIV_W        = NUMBER_WIDTH / 2 + 3;
    localparam int SQ_W         = NUMBER_WIDTH + 1;
    localparam int CNT_W        = $clog2(NUMBER_WIDTH + 1);

    localparam int FIRST_DIV    = 5;
    localparam int FIRST_SQ     = FIRST_DIV * FIRST_DIV;
    localparam int WHEEL_STEP   = 6;
    localparam int PAIR_OFS     = 2;
    localparam int THREE        = 3;
    localparam int SQ_GROW      = 2 * WHEEL_STEP;
    localparam int SQ_OFS       = WHEEL_STEP * WHEEL_STEP;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV3 = 6'b000010,
        ST_CHK  = 6'b000100,
        ST_DIVA = 6'b001000,
        ST_DIVB = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] divisor;
    } t_rem_ctl;

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_sts;

    typedef struct packed {
        logic valid;
        logic prime;
    } t_res;

endpackage
`default_nettype wire

@@ rtl/core/ptd_num_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_num_if
// Request channel carrying the number to test.
// ----------------------------------------------------------------------------
interface ptd_num_if import ptd_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [NUMBER_WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);

endinterface
`default_nettype wire

@@ rtl/core/ptd_res_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_res_if
// Result channel carrying the primality verdict.
// ----------------------------------------------------------------------------
interface ptd_res_if ();

    logic valid;
    logic ready;
    logic prime;

    modport source (output valid, output prime, input ready);
    modport sink   (input valid, input prime, output ready);

endinterface
`default_nettype wire

@@ rtl/core/primality_trial_division_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// primality_trial_division_top
// Trial-division primality tester over the 6k-1 / 6k+1 divisor wheel.
// ----------------------------------------------------------------------------
// One request in, one verdict out. Values up to 3 and even values are settled
// straight from the idle state; every other value first runs a remainder by 3,
// then one pair of remainders per wheel step in the bit-serial divider, with a
// square compare before each pair. A prime near the top of the 32-bit range
// needs about 10,900 divisor pairs, so the serial divider dominates the run
// time. A new request is taken as soon as the sequencer has handed its verdict
// to the output register, while that verdict may still wait to be taken.
// ----------------------------------------------------------------------------
module primality_trial_division_top import ptd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ptd_num_if.sink   i_req,
    ptd_res_if.source o_rsp
);

    t_rem_ctl                ctl;
    t_rem_sts                sts;
    t_res                    res;
    logic [NUMBER_WIDTH-1:0] dividend;
    logic                    res_ready;
    logic                    r_out_valid;
    logic                    r_out_prime;

    ptd_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_sts       (sts),
        .i_res_ready (res_ready),
        .o_ctl       (ctl),
        .o_dividend  (dividend),
        .o_res       (res)
    );

    ptd_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_dividend (dividend),
        .o_sts      (sts)
    );

    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) begin
            r_out_prime <= res.prime;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.prime = r_out_prime;

`ifndef NO_ASSERTIONS
    // even values are settled right away: prime only for two
    a_even_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && !i_req.number[0])
        |=> (res.valid && (res.prime == ($past(i_req.number) == NUMBER_WIDTH'(2)))))
        else $error("even request not settled in one cycle");

    // a division is never started while a new request can be taken
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.start |-> !i_req.ready)
        else $error("divider started while sequencer idle");

    // divider cannot finish right after a start
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.start |=> !sts.done)
        else $error("divider finished too early");
`endif

endmodule
`default_nettype wire

@@ rtl/core/ptd_rem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_rem
// Bit-serial remainder unit: one dividend bit per cycle, restoring step.
// ----------------------------------------------------------------------------
module ptd_rem import ptd_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_rem_ctl                i_ctl,
    input  wire logic [NUMBER_WIDTH-1:0] i_dividend,
    output t_rem_sts                     o_sts
);

    logic                    r_busy;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_done;
    logic                    r_zero;
    logic [DIV_W-1:0]        r_rem;
    logic [NUMBER_WIDTH-1:0] r_shift;

    logic [DIV_W:0]          trial;
    logic [DIV_W:0]          div_ext;
    logic [DIV_W-1:0]        n_rem;

    always_comb begin
        trial   = {r_rem, r_shift[NUMBER_WIDTH-1]};
        div_ext = {1'b0, i_ctl.divisor};
        if (trial >= div_ext) begin
            n_rem = DIV_W'(trial - div_ext);
        end else begin
            n_rem = trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUMBER_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem   <= '0;
            r_shift <= i_dividend;
        end else if (r_busy) begin
            r_rem   <= n_rem;
            r_shift <= {r_shift[NUMBER_WIDTH-2:0], 1'b0};
            r_zero  <= (n_rem == '0);
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.zero = r_zero;

endmodule
`default_nettype wire

@@ rtl/core/ptd_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_seq
// Sequencer: screens small and even values, divides by 3, then walks the
// 6k-1 / 6k+1 divisors while their square stays within the number.
// ----------------------------------------------------------------------------
module ptd_seq import ptd_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    ptd_num_if.sink                       i_req,
    input  wire t_rem_sts                 i_sts,
    input  wire logic                     i_res_ready,
    output t_rem_ctl                      o_ctl,
    output logic [NUMBER_WIDTH-1:0]       o_dividend,
    output t_res                          o_res
);

    t_state                  r_state, n_state;
    logic [NUMBER_WIDTH-1:0] r_n, n_n;
    logic [DIV_W-1:0]        r_d, n_d;
    logic [SQ_W-1:0]         r_sq, n_sq;
    logic                    r_start, n_start;
    logic [DIV_W-1:0]        r_div, n_div;
    logic                    r_prime, n_prime;

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_d     = r_d;
        n_sq    = r_sq;
        n_start = 1'b0;
        n_div   = r_div;
        n_prime = r_prime;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_n   = i_req.number;
                    n_d   = DIV_W'(FIRST_DIV);
                    n_sq  = SQ_W'(FIRST_SQ);
                    n_div = DIV_W'(THREE);
                    priority if (i_req.number <= NUMBER_WIDTH'(1)) begin
                        n_prime = 1'b0;
                        n_state = ST_DONE;
                    end else if (i_req.number <= NUMBER_WIDTH'(THREE)) begin
                        n_prime = 1'b1;
                        n_state = ST_DONE;
                    end else if (!i_req.number[0]) begin
                        n_prime = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        n_start = 1'b1;
                        n_state = ST_DIV3;
                    end
                end
            end
            ST_DIV3: begin
                if (i_sts.done) begin
                    if (i_sts.zero) begin
                        n_prime = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_CHK;
                    end
                end
            end
            ST_CHK: begin
                if (r_sq > {1'b0, r_n}) begin
                    n_prime = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_start = 1'b1;
                    n_div   = r_d;
                    n_state = ST_DIVA;
                end
            end
            ST_DIVA: begin
                if (i_sts.done) begin
                    if (i_sts.zero) begin
                        n_prime = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        n_start = 1'b1;
                        n_div   = r_d + DIV_W'(PAIR_OFS);
                        n_state = ST_DIVB;
                    end
                end
            end
            ST_DIVB: begin
                if (i_sts.done) begin
                    if (i_sts.zero) begin
                        n_prime = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        // (d+6)^2 = d^2 + 12d + 36
                        n_d     = r_d + DIV_W'(WHEEL_STEP);
                        n_sq    = r_sq + SQ_W'(r_d) * SQ_W'(SQ_GROW) + SQ_W'(SQ_OFS);
                        n_state = ST_CHK;
                    end
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_d     <= n_d;
        r_sq    <= n_sq;
        r_div   <= n_div;
        r_prime <= n_prime;
    end

    assign i_req.ready   = (r_state == ST_IDLE);
    assign o_ctl.start   = r_start;
    assign o_ctl.divisor = r_div;
    assign o_dividend    = r_n;
    assign o_res.valid   = (r_state == ST_DONE);
    assign o_res.prime   = r_prime;

endmodule
`default_nettype wire
